// File: sv/bcpe_pkg.sv
// Shared constants and types for the battery charge percent estimator.
package bcpe_pkg;

	localparam int unsigned MvWidth    = 13;
	localparam int unsigned PctWidth   = 7;
	localparam int unsigned VHystWidth = 10;
	localparam int unsigned CfgIdxWidth  = 2;
	localparam int unsigned CfgDataWidth = 10;

	// Curve limits and break points in mV.
	localparam logic [MvWidth-1:0] MvEmpty = 13'd3000;
	localparam logic [MvWidth-1:0] MvBrk0  = 13'd3500;
	localparam logic [MvWidth-1:0] MvBrk1  = 13'd3700;
	localparam logic [MvWidth-1:0] MvBrk2  = 13'd3900;
	localparam logic [MvWidth-1:0] MvBrk3  = 13'd4000;
	localparam logic [MvWidth-1:0] MvBrk4  = 13'd4100;
	localparam logic [MvWidth-1:0] MvFull  = 13'd4200;

	localparam logic [PctWidth-1:0] PctFull = 7'd100;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxWidth-1:0] CfgPercentHyst = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CfgVoltageHyst = 2'd1;

	localparam logic [PctWidth-1:0]   PctHystReset = 7'd3;
	localparam logic [VHystWidth-1:0] VHystReset   = 10'd20;

	typedef struct packed {
		logic                in_band; // strictly between empty and full limits
		logic [PctWidth-1:0] pct;
	} curve_t;

endpackage

// File: sv/bcpe_curve.sv
// Piecewise linear voltage to percentage map.
module bcpe_curve (
	input  logic [bcpe_pkg::MvWidth-1:0] mv,
	output bcpe_pkg::curve_t             curve
);

	logic [bcpe_pkg::MvWidth-1:0]  d;
	logic [9:0]                    num;
	logic [7:0]                    recip;
	logic [3:0]                    shift;
	logic [16:0]                   prod;
	logic [bcpe_pkg::PctWidth-1:0] base;
	logic [bcpe_pkg::PctWidth-1:0] quot;

	// Divisions by 50, 20, 10 and 5 as reciprocal multiplies; each is exact
	// over the range that its segment can reach.
	always_comb begin
		d     = '0;
		num   = '0;
		recip = 8'd205;
		shift = 4'd11;
		base  = '0;
		if (mv < bcpe_pkg::MvBrk0) begin
			d     = mv - bcpe_pkg::MvEmpty;
			num   = d[9:0];            // d/50
			recip = 8'd41;
			shift = 4'd11;
			base  = 7'd0;
		end else if (mv < bcpe_pkg::MvBrk1) begin
			d     = mv - bcpe_pkg::MvBrk0;
			num   = 10'(d[7:0] * 10'd3); // 3d/20
			recip = 8'd205;
			shift = 4'd12;
			base  = 7'd10;
		end else if (mv < bcpe_pkg::MvBrk2) begin
			d     = mv - bcpe_pkg::MvBrk1;
			num   = d[9:0];            // d/10
			shift = 4'd11;
			base  = 7'd40;
		end else if (mv < bcpe_pkg::MvBrk3) begin
			d     = mv - bcpe_pkg::MvBrk2;
			num   = d[9:0];            // d/5
			shift = 4'd10;
			base  = 7'd60;
		end else if (mv < bcpe_pkg::MvBrk4) begin
			d     = mv - bcpe_pkg::MvBrk3;
			num   = d[9:0];
			shift = 4'd11;
			base  = 7'd80;
		end else begin
			d     = mv - bcpe_pkg::MvBrk4;
			num   = d[9:0];
			shift = 4'd11;
			base  = 7'd90;
		end
		prod = 17'(num) * 17'(recip);
		quot = 7'(prod >> shift);

		if (mv <= bcpe_pkg::MvEmpty) begin
			curve.in_band = 1'b0;
			curve.pct     = '0;
		end else if (mv >= bcpe_pkg::MvFull) begin
			curve.in_band = 1'b0;
			curve.pct     = bcpe_pkg::PctFull;
		end else begin
			curve.in_band = 1'b1;
			curve.pct     = base + quot;
		end
	end

endmodule

// File: sv/battery_charge_percent_estimator.sv
// Top level: sample register, curve and hysteresis, result register.
// Throughput: one item per cycle unless out_ready stalls the output; the held
// state is updated at the same edge that loads the result register, so the next
// item sees it without a bubble.
// Reset: arst_n clears valids, held state and sample flag, and loads the
// hysteresis registers with 3 percent and 20 mV.
module battery_charge_percent_estimator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [bcpe_pkg::MvWidth-1:0]         millivolts,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bcpe_pkg::PctWidth-1:0]        charge_percent,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bcpe_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [bcpe_pkg::CfgDataWidth-1:0]    cfg_data
);

	logic                              valid_s1;
	logic [bcpe_pkg::MvWidth-1:0]      mv_s1;
	logic                              out_valid_q;
	logic [bcpe_pkg::PctWidth-1:0]     out_q;
	logic [bcpe_pkg::PctWidth-1:0]     pct_hyst_q;
	logic [bcpe_pkg::VHystWidth-1:0]   v_hyst_q;
	logic [bcpe_pkg::PctWidth-1:0]     held_pct_q;
	logic [bcpe_pkg::MvWidth-1:0]      held_mv_q;
	logic                              have_q;

	bcpe_pkg::curve_t                  curve;
	logic                              adv;
	logic                              update;
	logic [bcpe_pkg::MvWidth-1:0]      mv_diff;
	logic [bcpe_pkg::PctWidth-1:0]     pct_diff;
	logic [bcpe_pkg::PctWidth-1:0]     result;

	bcpe_curve u_curve (
		.mv    (mv_s1),
		.curve (curve)
	);

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign charge_percent = out_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		mv_diff  = (mv_s1 > held_mv_q) ? mv_s1 - held_mv_q : held_mv_q - mv_s1;
		pct_diff = (curve.pct > held_pct_q) ? curve.pct - held_pct_q
		                                    : held_pct_q - curve.pct;
		update = curve.in_band && (!have_q
			|| mv_diff > {3'b000, v_hyst_q}
			|| pct_diff > pct_hyst_q);
		if (!curve.in_band) begin
			result = curve.pct;
		end else if (update) begin
			result = curve.pct;
		end else begin
			result = held_pct_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			have_q      <= 1'b0;
			held_pct_q  <= '0;
			held_mv_q   <= '0;
			pct_hyst_q  <= bcpe_pkg::PctHystReset;
			v_hyst_q    <= bcpe_pkg::VHystReset;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv && update) begin
				have_q     <= 1'b1;
				held_pct_q <= curve.pct;
				held_mv_q  <= mv_s1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bcpe_pkg::CfgPercentHyst: pct_hyst_q <= cfg_data[bcpe_pkg::PctWidth-1:0];
					bcpe_pkg::CfgVoltageHyst: v_hyst_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mv_s1 <= millivolts;
		end
		if (adv) begin
			out_q <= result;
		end
	end

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> charge_percent <= bcpe_pkg::PctFull)
		else $error("charge_percent above full scale");

	a_have_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |=> have_q)
		else $error("sample flag cleared");

	a_held_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(held_pct_q) && $stable(held_mv_q))
		else $error("held state changed without an item");

	a_held_band: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> held_mv_q > bcpe_pkg::MvEmpty && held_mv_q < bcpe_pkg::MvFull)
		else $error("held voltage outside curve band");

endmodule
